@@ hw/rtl/lcsp_pkg.sv @@
// Shared types, character codes and key strings for the line command switch parser.
package lcsp_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scan_stat;

    typedef struct packed {
        logic [7:0] lamp;
        logic [7:0] fan;
        logic [7:0] alarm;
    } t_sw_vals;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam int PFX_LEN   = 12;
    localparam int LAMP_LEN  = 17;
    localparam int FAN_LEN   = 12;
    localparam int ALARM_LEN = 14;
    // window spans the key position up to the byte tested for an early CR
    localparam int WIN_LEN   = 19;

    localparam logic [7:0] SCAN_START_RST = 8'd130;

    localparam logic [7:0] PFX_TXT [PFX_LEN] = '{
        CHAR_PLUS, "M", "Q", "T", "T", "S", "U", "B", "R", "E", "C", "V"
    };

    localparam logic [7:0] LAMP_KEY [LAMP_LEN] = '{
        CHAR_QUOTE, "M", "a", "i", "n", "L", "a", "m", "p",
        "S", "w", "i", "t", "c", "h", CHAR_QUOTE, CHAR_COLON
    };

    localparam logic [7:0] FAN_KEY [FAN_LEN] = '{
        CHAR_QUOTE, "F", "a", "n", "S", "w", "i", "t", "c", "h", CHAR_QUOTE, CHAR_COLON
    };

    localparam logic [7:0] ALARM_KEY [ALARM_LEN] = '{
        CHAR_QUOTE, "A", "l", "a", "r", "m",
        "S", "w", "i", "t", "c", "h", CHAR_QUOTE, CHAR_COLON
    };

    // active-low drive: '1' turns on, '0' turns off, anything else holds
    function automatic logic drive_next(logic cur_bit, logic [7:0] val);
        logic res;
        res = cur_bit;
        if (val == CHAR_ONE) begin
            res = 1'b0;
        end else if (val == CHAR_ZERO) begin
            res = 1'b1;
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/lcsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lcsp_scan.sv @@
// Key scan: streams line bytes from the RAM through a window and captures switch values.
module lcsp_scan #(
    parameter int LINE_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_go,
    input  logic [((($clog2(LINE_DEPTH) > 8) ? $clog2(LINE_DEPTH) : 8) + 1)-1:0] i_first,
    input  logic [((($clog2(LINE_DEPTH) > 8) ? $clog2(LINE_DEPTH) : 8) + 1)-1:0] i_cr,
    output logic                             o_rd_en,
    output logic [$clog2(LINE_DEPTH)-1:0]    o_rd_addr,
    input  logic [7:0]                       i_rd_data,
    output lcsp_pkg::t_scan_stat             o_stat,
    output lcsp_pkg::t_sw_vals               o_vals
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int PW = ((AW > 8) ? AW : 8) + 1;
    localparam int CW = $clog2(lcsp_pkg::WIN_LEN);
    localparam logic [CW-1:0] CNT_FULL = CW'(lcsp_pkg::WIN_LEN - 1);

    logic               r_busy;
    logic [PW-1:0]      r_pos;
    logic [PW-1:0]      r_cr;
    logic               r_rd_vld;
    logic               r_stop;
    logic [CW-1:0]      r_cnt;
    logic [7:0]         r_win [lcsp_pkg::WIN_LEN];
    lcsp_pkg::t_sw_vals r_vals;

    logic               issue;
    logic               finish;
    logic               full;
    logic [7:0]         w [lcsp_pkg::WIN_LEN];
    logic               lamp_hit;
    logic               fan_hit;
    logic               alarm_hit;
    logic               hit_cr;

    assign issue  = r_busy && !r_stop && (r_pos < r_cr);
    assign finish = r_busy && !issue && !r_rd_vld;
    assign full   = (r_cnt == CNT_FULL);

    // window as it stands with the returning byte shifted in at the top
    always_comb begin
        for (int k = 0; k < lcsp_pkg::WIN_LEN - 1; k++) begin
            w[k] = r_win[k + 1];
        end
        w[lcsp_pkg::WIN_LEN - 1] = i_rd_data;
    end

    always_comb begin
        lamp_hit  = 1'b1;
        fan_hit   = 1'b1;
        alarm_hit = 1'b1;
        for (int k = 0; k < lcsp_pkg::LAMP_LEN; k++) begin
            lamp_hit = lamp_hit && (w[k] == lcsp_pkg::LAMP_KEY[k]);
        end
        for (int k = 0; k < lcsp_pkg::FAN_LEN; k++) begin
            fan_hit = fan_hit && (w[k] == lcsp_pkg::FAN_KEY[k]);
        end
        for (int k = 0; k < lcsp_pkg::ALARM_LEN; k++) begin
            alarm_hit = alarm_hit && (w[k] == lcsp_pkg::ALARM_KEY[k]);
        end
        hit_cr = (w[lcsp_pkg::WIN_LEN - 1] == lcsp_pkg::CHAR_CR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_stop      <= 1'b0;
            r_cnt       <= '0;
            r_vals.lamp  <= lcsp_pkg::CHAR_ZERO;
            r_vals.fan   <= lcsp_pkg::CHAR_ZERO;
            r_vals.alarm <= lcsp_pkg::CHAR_ZERO;
        end else if (i_go) begin
            r_busy   <= 1'b1;
            r_rd_vld <= 1'b0;
            r_stop   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_rd_vld <= issue;
            if (finish) begin
                r_busy <= 1'b0;
            end
            if (r_rd_vld) begin
                if (!full) begin
                    r_cnt <= r_cnt + 1'b1;
                end else if (!r_stop) begin
                    // stop at a CR at the far end of the window
                    if (hit_cr) begin
                        r_stop <= 1'b1;
                    end else begin
                        if (lamp_hit) begin
                            r_vals.lamp <= w[lcsp_pkg::LAMP_LEN];
                        end
                        if (fan_hit) begin
                            r_vals.fan <= w[lcsp_pkg::FAN_LEN];
                        end
                        if (alarm_hit) begin
                            r_vals.alarm <= w[lcsp_pkg::ALARM_LEN];
                        end
                    end
                end
            end
        end
    end

    // read position and window data need no reset
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_pos <= i_first;
            r_cr  <= i_cr;
        end else if (issue) begin
            r_pos <= r_pos + 1'b1;
        end
        if (r_rd_vld) begin
            for (int k = 0; k < lcsp_pkg::WIN_LEN; k++) begin
                r_win[k] <= w[k];
            end
        end
    end

    assign o_rd_en     = issue;
    assign o_rd_addr   = r_pos[AW-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = finish;
    assign o_vals      = r_vals;

endmodule

@@ hw/rtl/line_command_switch_parser.sv @@
// Top level: line collection, command detection, key scan control and drive outputs.
//
//   channel   direction  handshake                 payload
//   ------    ---------  ------------------------  ------------------------------------------
//   in        sink       i_in_valid / o_in_stall   i_rx_byte
//   out       source     o_out_valid / i_out_stall o_lamp_drive, o_fan_drive, o_alarm_drive,
//                                                  o_command_applied
//   cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_data (scan_start)
//
// Every received word yields one result word. An ordinary byte is written to the line RAM
// and its result lands in the output register at the same edge.
// A byte that completes a "+MQTTSUBRECV" line starts the key scan, which reads one RAM
// position per cycle from scan_start up to the CR, through the single read port of the
// line RAM.
// Reset (synchronous, active low) clears the fill position, switch values and drives;
// the line RAM needs no clearing, since only positions of the current line are read.
// The input stalls during a scan and while a finished result waits and is stalled.
module line_command_switch_parser #(
    parameter int LINE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_lamp_drive,
    output logic       o_fan_drive,
    output logic       o_alarm_drive,
    output logic       o_command_applied,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int PW = ((AW > 8) ? AW : 8) + 1;
    localparam logic [AW-1:0] FILL_LAST = AW'(LINE_DEPTH - 1);
    localparam logic [AW-1:0] PFX_END   = AW'(lcsp_pkg::PFX_LEN);

    lcsp_pkg::t_state     r_state;
    lcsp_pkg::t_state     n_state;
    logic [AW-1:0]        r_fill;
    logic [AW-1:0]        n_fill;
    logic                 r_pfx;
    logic                 n_pfx;
    logic                 r_prev_cr;
    logic [7:0]           r_scan_start;
    logic [2:0]           r_drv;
    logic [2:0]           n_drv;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_applied;
    logic                 n_applied;

    logic                 out_free;
    logic                 in_acc;
    logic                 line_done;
    logic                 is_cmd;
    logic                 first_ok;
    logic                 scan_go;
    logic [PW-1:0]        scan_first;
    logic [PW-1:0]        scan_cr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           rd_data;
    lcsp_pkg::t_scan_stat scan_stat;
    lcsp_pkg::t_sw_vals   sw_vals;

    // output register is free when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == lcsp_pkg::S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    // LF right after a CR inside the current line closes it
    assign line_done = (r_fill != '0) && r_prev_cr && (i_rx_byte == lcsp_pkg::CHAR_LF);
    // prefix flag is only complete once all twelve prefix positions are in
    assign is_cmd    = line_done && (r_fill >= PFX_END) && r_pfx;
    // a line only starts on '+'
    assign first_ok  = (r_fill != '0) || (i_rx_byte == lcsp_pkg::CHAR_PLUS);

    assign scan_go    = in_acc && is_cmd;
    assign scan_first = PW'(r_scan_start);
    assign scan_cr    = PW'(r_fill) - 1'b1;

    // fill position and running prefix check
    always_comb begin
        n_fill = r_fill;
        n_pfx  = r_pfx;
        if (in_acc) begin
            if (line_done || !first_ok || (r_fill == FILL_LAST)) begin
                // drop the line: completed, no leading '+', or store full
                n_fill = '0;
            end else begin
                n_fill = r_fill + 1'b1;
            end
            if (r_fill == '0) begin
                n_pfx = (i_rx_byte == lcsp_pkg::CHAR_PLUS);
            end else if (r_fill < PFX_END) begin
                n_pfx = r_pfx && (i_rx_byte == lcsp_pkg::PFX_TXT[r_fill[3:0]]);
            end
        end
    end

    // control: idle accepts bytes, scan walks the line, apply updates the drives
    always_comb begin
        n_state     = r_state;
        n_drv       = r_drv;
        n_applied   = r_applied;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            lcsp_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (is_cmd) begin
                        n_state = lcsp_pkg::S_SCAN;
                    end else begin
                        // hold drives, report a plain byte
                        n_out_valid = 1'b1;
                        n_applied   = 1'b0;
                    end
                end
            end
            lcsp_pkg::S_SCAN: begin
                if (scan_stat.done) begin
                    n_state = lcsp_pkg::S_APPLY;
                end
            end
            lcsp_pkg::S_APPLY: begin
                if (out_free) begin
                    n_drv[0]    = lcsp_pkg::drive_next(r_drv[0], sw_vals.lamp);
                    n_drv[1]    = lcsp_pkg::drive_next(r_drv[1], sw_vals.fan);
                    n_drv[2]    = lcsp_pkg::drive_next(r_drv[2], sw_vals.alarm);
                    n_out_valid = 1'b1;
                    n_applied   = 1'b1;
                    n_state     = lcsp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lcsp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lcsp_pkg::S_IDLE;
            r_fill       <= '0;
            r_pfx        <= 1'b0;
            r_prev_cr    <= 1'b0;
            r_scan_start <= lcsp_pkg::SCAN_START_RST;
            r_drv        <= 3'b111;
            r_out_valid  <= 1'b0;
            r_applied    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pfx       <= n_pfx;
            r_drv       <= n_drv;
            r_out_valid <= n_out_valid;
            r_applied   <= n_applied;
            if (in_acc) begin
                r_prev_cr <= (i_rx_byte == lcsp_pkg::CHAR_CR);
            end
            if (i_cfg_valid) begin
                r_scan_start <= i_cfg_data;
            end
        end
    end

    // line store: written by each accepted byte, read by the key scan
    lcsp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_fill),
        .i_wdata (i_rx_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    lcsp_scan #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (scan_go),
        .i_first   (scan_first),
        .i_cr      (scan_cr),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_stat    (scan_stat),
        .o_vals    (sw_vals)
    );

    assign o_out_valid       = r_out_valid;
    assign o_lamp_drive      = r_drv[0];
    assign o_fan_drive       = r_drv[1];
    assign o_alarm_drive     = r_drv[2];
    assign o_command_applied = r_applied;
    assign o_cfg_ready       = 1'b1;

endmodule
